FILE: rtl/core/btp_pkg.sv
package btp_pkg;

	localparam int INDEX_BITS = 16;
	localparam int SIZE_BITS  = INDEX_BITS + 1;
	localparam int LEVELS     = INDEX_BITS + 2;

	typedef struct packed {
		logic                  live;
		logic                  done;
		logic                  valid;
		logic                  has_cand;
		logic [1:0]            kids;
		logic [INDEX_BITS-1:0] idx;
		logic [INDEX_BITS-1:0] seg_start;
		logic [SIZE_BITS-1:0]  seg_size;
		logic [INDEX_BITS-1:0] cand;
	} walk_t;

	// isolate the leading one of v
	function automatic logic [SIZE_BITS-1:0] lead_pow(input logic [SIZE_BITS-1:0] v);
		logic [SIZE_BITS-1:0] p;
		p = '0;
		for (int i = 0; i < SIZE_BITS; i++) begin
			if (v[i]) begin
				p = '0;
				p[i] = 1'b1;
			end
		end
		return p;
	endfunction

endpackage

FILE: rtl/core/binary_tree_parent_calc.sv
// In-order binary tree link lookup.
// cfg channel: cfg_valid/cfg_ready/cfg_data writes node_count; cfg_ready is
// always high, so a write takes effect at the edge where cfg_valid is high.
// Write it only while busy is low.
// Query: node_index is taken at an edge where start is high and busy is low.
// busy then stays high until the result has been loaded.
// The query walks a row of INDEX_BITS+2 cells, one tree level per cell and
// one cell per cycle; the walk length is fixed by that row.
// Result: done pulses for one cycle with parent_index, is_root, child_count
// and index_valid; a new query can be taken in that same cycle, so only one
// query is in the row at a time.
// The result is shown for exactly one cycle; there is no back pressure.
// Reset: node_count returns to 1, the row is emptied and busy/done are low.
module binary_tree_parent_calc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [btp_pkg::INDEX_BITS-1:0] cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic [btp_pkg::INDEX_BITS-1:0] node_index,
	output logic                           done,
	output logic [btp_pkg::INDEX_BITS-1:0] parent_index,
	output logic                           is_root,
	output logic [1:0]                     child_count,
	output logic                           index_valid
);
	import btp_pkg::*;

	logic [INDEX_BITS-1:0] node_count_q;
	logic                  busy_q;
	logic                  done_q;
	logic [INDEX_BITS-1:0] parent_q;
	logic                  root_q;
	logic [1:0]            kids_q;
	logic                  valid_q;
	logic                  accept;
	walk_t                 head;
	walk_t                 chain [LEVELS+1];
	logic [LEVELS-1:0]     live_vec;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= INDEX_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	always_comb begin
		head           = '0;
		head.live      = accept;
		head.done      = (node_index >= node_count_q);
		head.idx       = node_index;
		head.seg_size  = {1'b0, node_count_q};
	end

	assign chain[0] = head;

	for (genvar g = 0; g < LEVELS; g++) begin : g_row
		btp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
		assign live_vec[g] = chain[g+1].live;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= chain[LEVELS].live;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (chain[LEVELS].live) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain[LEVELS].live) begin
			valid_q  <= chain[LEVELS].valid;
			root_q   <= chain[LEVELS].valid && !chain[LEVELS].has_cand;
			kids_q   <= chain[LEVELS].valid ? chain[LEVELS].kids : 2'd0;
			parent_q <= (chain[LEVELS].valid && chain[LEVELS].has_cand) ?
				chain[LEVELS].cand : '0;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign parent_index = parent_q;
	assign is_root      = root_q;
	assign child_count  = kids_q;
	assign index_valid  = valid_q;

	// one word in flight at a time
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one word in the cell row");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("busy not raised after accept");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_root_links: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_root) |-> (index_valid && parent_index == '0))
		else $error("root result with parent or invalid flag");

endmodule

FILE: rtl/core/btp_cell.sv
module btp_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  btp_pkg::walk_t d,
	output btp_pkg::walk_t q
);
	import btp_pkg::*;

	walk_t                 n;
	logic [SIZE_BITS-1:0]  pw;
	logic [SIZE_BITS-1:0]  root_w;
	logic [INDEX_BITS-1:0] root;

	assign pw     = lead_pow(d.seg_size);
	assign root_w = {1'b0, d.seg_start} + pw - SIZE_BITS'(1);
	assign root   = root_w[INDEX_BITS-1:0];

	always_comb begin
		n = d;
		if (d.live && !d.done) begin
			if (d.seg_size == '0) begin
				n.done = 1'b1;
			end else if (d.seg_size == SIZE_BITS'(1)) begin
				n.done = 1'b1;
				if (d.seg_start == d.idx) begin
					n.valid = 1'b1;
					n.kids  = 2'd0;
				end
			end else if (d.idx == root) begin
				n.done  = 1'b1;
				n.valid = 1'b1;
				n.kids  = (d.seg_size != pw) ? 2'd2 : 2'd1;
			end else if (d.idx < root) begin
				n.cand     = root;
				n.has_cand = 1'b1;
				n.seg_size = pw - SIZE_BITS'(1);
			end else begin
				n.cand      = root;
				n.has_cand  = 1'b1;
				n.seg_start = root + INDEX_BITS'(1);
				n.seg_size  = d.seg_size - pw;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= n;
		end
	end

endmodule
